// File: hw/rtl/bss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bass saturation package
// Configuration bundle, engine handshake structs, register indexes and
// reset values shared by the core and its engine.
// ----------------------------------------------------------------------------
package bss_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;
   localparam int COEF_W     = 20;
   localparam int STATE_W    = 40;

   localparam logic [CSR_IDX_W-1:0] REG_HP_COEFS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LP_COEFS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SUB       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BLEND     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_GAIN  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_IN_GAIN   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_BYPASS    = 3'd7;

   localparam logic [15:0] DRIVE_RESET    = 16'd18432;
   localparam logic [13:0] SUB_RESET      = 14'd8173;
   localparam logic [12:0] BLEND_RESET    = 13'd2867;
   localparam logic [13:0] OUT_GAIN_RESET = 14'd4096;
   localparam logic [15:0] IN_GAIN_RESET  = 16'd4096;

   typedef struct packed {
      logic [59:0] hp_coefs;
      logic [59:0] lp_coefs;
      logic [15:0] drive_gain;
      logic [13:0] sub_gain;
      logic [12:0] blend_amount;
      logic [13:0] output_gain;
      logic [15:0] input_gain;
      logic        bypass_on;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic ack;
   } eng_ctl_type;

   typedef struct packed {
      logic done;
   } eng_sts_type;

endpackage

// File: hw/rtl/bass_saturation_stereo_channel_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bass saturation stereo core
// Per channel: input gain, highpass into drive and tanh, lowpass sub path,
// dry/wet blend and output gain with saturation. Bypass passes samples.
// ----------------------------------------------------------------------------
// Each channel of an item runs in turn through the shared multiplier
// sequence; bypass returns the samples without it. One item at a time:
// a new item is taken only once the last has moved to the output register.
// The pace is set by the single multiplier and the state memory port; a
// finished item waits in the output register. Reset: synchronous; registers
// take their reset values, filter state reads as zero until written.
module bass_saturation_stereo_channel_core import bss_pkg::*; #(
   parameter int CHANNELS     = 2,
   parameter int TANH_ENTRIES = 1024,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_result,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_result,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   cfg_type     cfg_ff;
   eng_ctl_type ctl;
   eng_sts_type sts;
   logic        busy_ff;
   logic        rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_right_ff;
   logic signed [SAMPLE_BITS-1:0] eng_left, eng_right;
   logic        load;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hp_coefs     <= '0;
         cfg_ff.lp_coefs     <= '0;
         cfg_ff.drive_gain   <= DRIVE_RESET;
         cfg_ff.sub_gain     <= SUB_RESET;
         cfg_ff.blend_amount <= BLEND_RESET;
         cfg_ff.output_gain  <= OUT_GAIN_RESET;
         cfg_ff.input_gain   <= IN_GAIN_RESET;
         cfg_ff.bypass_on    <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_HP_COEFS: cfg_ff.hp_coefs     <= csr_wdata[59:0];
            REG_LP_COEFS: cfg_ff.lp_coefs     <= csr_wdata[59:0];
            REG_DRIVE:    cfg_ff.drive_gain   <= csr_wdata[15:0];
            REG_SUB:      cfg_ff.sub_gain     <= csr_wdata[13:0];
            REG_BLEND:    cfg_ff.blend_amount <= csr_wdata[12:0];
            REG_OUT_GAIN: cfg_ff.output_gain  <= csr_wdata[13:0];
            REG_IN_GAIN:  cfg_ff.input_gain   <= csr_wdata[15:0];
            REG_BYPASS:   cfg_ff.bypass_on    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready = !busy_ff;
   assign ctl.start = req_valid && !busy_ff;
   // The engine hands over its item once the output register is free.
   assign load      = sts.done && (!rsp_valid_ff || rsp_ready);
   assign ctl.ack   = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.start) begin
            busy_ff <= 1'b1;
         end else if (load) begin
            busy_ff <= 1'b0;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_left_ff  <= eng_left;
         rsp_right_ff <= eng_right;
      end
   end

   bss_engine #(
      .CHANNELS     (CHANNELS),
      .TANH_ENTRIES (TANH_ENTRIES),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .ctl          (ctl),
      .left_sample  (req_left_sample),
      .right_sample (req_right_sample),
      .sts          (sts),
      .left_result  (eng_left),
      .right_result (eng_right)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_result  = rsp_left_ff;
   assign rsp_right_result = rsp_right_ff;

endmodule

// File: hw/rtl/bss_state_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filter state memory
// One entry per channel holding both biquads' delay words. Synchronous read
// with registered data; entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module bss_state_mem import bss_pkg::*; #(
   parameter int DEPTH = 2,
   parameter int AW    = 1,
   parameter int WIDTH = 4 * STATE_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bss_tanh_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tanh table
// Read-only table of tanh over [-4,4] in Q1.23, built at elaboration from an
// odd series and six argument doublings. Two registered read ports.
// ----------------------------------------------------------------------------
module bss_tanh_rom #(
   parameter int ENTRIES = 1024,
   parameter int TI      = 10
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [TI-1:0]       addr_lo,
   input  logic [TI-1:0]       addr_hi,
   output logic signed [23:0]  data_lo,
   output logic signed [23:0]  data_hi
);

   localparam logic [63:0] NM1 = 64'(ENTRIES - 1);

   typedef logic signed [23:0] tbl_type [ENTRIES];

   function automatic logic [63:0] div_u(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], num[i]};
         if (r >= {1'b0, den}) begin
            r = r - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] tanh_q30(input logic [63:0] m);
      logic [63:0] x, x2, x3, x5, x7, t, den;
      x  = m >> 6;
      x2 = (x * x) >> 30;
      x3 = (x2 * x) >> 30;
      x5 = (x3 * x2) >> 30;
      x7 = (x5 * x2) >> 30;
      t  = x - x3 / 64'd3 + (64'd2 * x5) / 64'd15 - (64'd17 * x7) / 64'd315;
      for (int k = 0; k < 6; k++) begin
         den = (64'd1 << 30) + ((t * t) >> 30);
         t   = div_u((t << 31) + (den >> 1), den);
      end
      return t;
   endfunction

   function automatic tbl_type build_tbl();
      tbl_type     tbl;
      logic [63:0] num, mag, t;
      logic signed [63:0] u;
      for (int i = 0; i < ENTRIES; i++) begin
         num = 64'(i) << 33;
         u   = $signed((num + NM1 / 64'd2) / NM1) - (64'sd1 <<< 32);
         mag = (u < 0) ? 64'(-u) : 64'(u);
         t   = (tanh_q30(mag) + 64'd64) >> 7;
         tbl[i] = (u < 0) ? 24'(-t) : 24'(t);
      end
      return tbl;
   endfunction

   localparam tbl_type TBL = build_tbl();

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_lo <= TBL[addr_lo];
         data_hi <= TBL[addr_hi];
      end
   end

endmodule

// File: hw/rtl/bss_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel engine
// Sequencer around one shared registered multiplier. For each channel it
// reads the filter state, runs both biquads, writes back, shapes and mixes.
// ----------------------------------------------------------------------------
module bss_engine import bss_pkg::*; #(
   parameter int CHANNELS     = 2,
   parameter int TANH_ENTRIES = 1024,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  eng_ctl_type                   ctl,
   input  logic signed [SAMPLE_BITS-1:0] left_sample,
   input  logic signed [SAMPLE_BITS-1:0] right_sample,
   output eng_sts_type                   sts,
   output logic signed [SAMPLE_BITS-1:0] left_result,
   output logic signed [SAMPLE_BITS-1:0] right_result
);

   localparam int ACTIVE = (CHANNELS < 2) ? 1 : 2;
   localparam int SH     = SAMPLE_BITS - 24;
   localparam int NARROW = (SH > 0) ? SH : 0;
   localparam int WIDEN  = (SH < 0) ? -SH : 0;
   localparam int TI     = $clog2(TANH_ENTRIES);
   localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MW     = 4 * STATE_W;
   localparam logic signed [63:0] FOUR = 64'sd1 <<< 44;
   localparam logic signed [63:0] ONE23 = 64'sd1 <<< 23;

   typedef enum logic [4:0] {
      S_IDLE, S_GAIN, S_LOAD, S_HB0, S_LB0, S_HA1, S_HA2, S_LA1, S_LA2,
      S_DRV, S_SUB, S_POS, S_ROM, S_INTP, S_DIFF, S_BLEND, S_MIX, S_OG,
      S_OUT, S_DONE
   } state_type;

   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic logic signed [63:0] sat_to(input logic signed [63:0] v,
                                                 input int bits);
      logic signed [63:0] hi, lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   state_type state_ff;
   logic      ch_ff;
   logic signed [SAMPLE_BITS-1:0] samp_ff [2];
   logic signed [SAMPLE_BITS-1:0] res_ff [2];
   logic signed [63:0] prod_ff;
   logic signed [29:0] x_ff;
   logic signed [STATE_W-1:0] hs1_ff, hs2_ff, ls1_ff, ls2_ff;
   logic signed [STATE_W-1:0] hy_ff, ly_ff;
   logic signed [STATE_W-1:0] hs1n_ff, hs2n_ff, ls1n_ff, ls2n_ff;
   logic signed [49:0] hp0_ff, lp0_ff;
   logic signed [57:0] arg_ff;
   logic signed [35:0] sub_ff;
   logic [15:0]        frac_ff;
   logic signed [37:0] diff_ff;
   logic signed [39:0] m_ff;

   logic signed [47:0] mul_a;
   logic signed [21:0] mul_b;
   logic signed [69:0] mul_full;
   logic signed [63:0] a_wide, b_wide, in23;

   logic signed [63:0] x_new, hy_new, ly_new, hs1_new, hs2_new, ls1_new, ls2_new;
   logic signed [63:0] sub_new, shaped, diff_new, m_new, o_val;
   logic [TI-1:0]      idx, idx_raw;
   logic [MW-1:0]      mem_rdata;
   logic signed [23:0] tbl_lo, tbl_hi;

   logic signed [COEF_W-1:0] hb0, ha1, ha2, lb0, la1, la2;
   assign hb0 = cfg.hp_coefs[19:0];
   assign ha1 = cfg.hp_coefs[39:20];
   assign ha2 = cfg.hp_coefs[59:40];
   assign lb0 = cfg.lp_coefs[19:0];
   assign la1 = cfg.lp_coefs[39:20];
   assign la2 = cfg.lp_coefs[59:40];

   // Sample converted to the internal Q.23 scale.
   always_comb begin
      in23 = 64'(samp_ff[ch_ff]);
      if (NARROW > 0) begin
         in23 = rnd_shift(in23, NARROW);
      end else if (WIDEN > 0) begin
         in23 = in23 <<< WIDEN;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      a_wide = '0;
      b_wide = '0;
      case (state_ff)
         S_GAIN: begin
            a_wide = in23;
            b_wide = $signed({48'd0, cfg.input_gain});
         end
         S_HB0: begin
            a_wide = 64'(x_ff);
            b_wide = 64'(hb0);
         end
         S_LB0: begin
            a_wide = 64'(x_ff);
            b_wide = 64'(lb0);
         end
         S_HA1: begin
            a_wide = 64'(hy_ff);
            b_wide = 64'(ha1);
         end
         S_HA2: begin
            a_wide = 64'(hy_ff);
            b_wide = 64'(ha2);
         end
         S_LA1: begin
            a_wide = 64'(ly_ff);
            b_wide = 64'(la1);
         end
         S_LA2: begin
            a_wide = 64'(ly_ff);
            b_wide = 64'(la2);
         end
         S_DRV: begin
            a_wide = 64'(hy_ff);
            b_wide = $signed({48'd0, cfg.drive_gain});
         end
         S_SUB: begin
            a_wide = 64'(ly_ff);
            b_wide = $signed({50'd0, cfg.sub_gain});
         end
         S_POS: begin
            a_wide = 64'(arg_ff) + FOUR;
            b_wide = 64'(TANH_ENTRIES - 1);
         end
         S_INTP: begin
            a_wide = 64'(tbl_hi) - 64'(tbl_lo);
            b_wide = $signed({48'd0, frac_ff});
         end
         S_BLEND: begin
            a_wide = 64'(diff_ff);
            b_wide = $signed({51'd0, cfg.blend_amount});
         end
         S_OG: begin
            a_wide = 64'(m_ff);
            b_wide = $signed({50'd0, cfg.output_gain});
         end
         default: begin
            a_wide = '0;
            b_wide = '0;
         end
      endcase
   end

   assign mul_a    = a_wide[47:0];
   assign mul_b    = b_wide[21:0];
   assign mul_full = mul_a * mul_b;

   // Results taken from the product of the previous step.
   always_comb begin
      x_new   = rnd_shift(prod_ff, 12);
      hy_new  = sat_to(rnd_shift(prod_ff, 11) + 64'(hs1_ff), STATE_W);
      ly_new  = sat_to(rnd_shift(prod_ff, 11) + 64'(ls1_ff), STATE_W);
      hs1_new = sat_to(rnd_shift(-(64'(hp0_ff) <<< 8) - prod_ff, 18) + 64'(hs2_ff),
                       STATE_W);
      hs2_new = sat_to(rnd_shift((64'(hp0_ff) <<< 7) - prod_ff, 18), STATE_W);
      ls1_new = sat_to(rnd_shift((64'(lp0_ff) <<< 8) - prod_ff, 18) + 64'(ls2_ff),
                       STATE_W);
      ls2_new = sat_to(rnd_shift((64'(lp0_ff) <<< 7) - prod_ff, 18), STATE_W);
      sub_new = rnd_shift(prod_ff, 19);
      if (64'(arg_ff) >= FOUR) begin
         shaped = ONE23;
      end else if (64'(arg_ff) <= -FOUR) begin
         shaped = -ONE23;
      end else begin
         shaped = 64'(tbl_lo) + rnd_shift(prod_ff, 16);
      end
      diff_new = shaped + 64'(sub_ff) - 64'(x_ff);
      m_new    = rnd_shift((64'(x_ff) <<< 12) + prod_ff, 12);
      o_val    = rnd_shift(prod_ff, 12);
      if (NARROW > 0) begin
         o_val = sat_to(o_val, STATE_W) <<< NARROW;
      end else if (WIDEN > 0) begin
         o_val = rnd_shift(o_val, WIDEN);
      end
      o_val = sat_to(o_val, SAMPLE_BITS);
   end

   // The index of a position inside (-4,4) never passes the last pair.
   assign idx_raw = prod_ff[45 +: TI];
   assign idx = (idx_raw > TI'(TANH_ENTRIES - 2)) ? TI'(TANH_ENTRIES - 2) : idx_raw;

   always_ff @(posedge clock) begin
      prod_ff <= mul_full[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ch_ff    <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (ctl.start) begin
                  samp_ff[0] <= left_sample;
                  samp_ff[1] <= right_sample;
                  res_ff[0]  <= left_sample;
                  res_ff[1]  <= right_sample;
                  ch_ff      <= 1'b0;
                  state_ff   <= cfg.bypass_on ? S_DONE : S_GAIN;
               end
            end
            S_GAIN:  state_ff <= S_LOAD;
            S_LOAD: begin
               x_ff   <= x_new[29:0];
               hs1_ff <= mem_rdata[4*STATE_W-1 -: STATE_W];
               hs2_ff <= mem_rdata[3*STATE_W-1 -: STATE_W];
               ls1_ff <= mem_rdata[2*STATE_W-1 -: STATE_W];
               ls2_ff <= mem_rdata[STATE_W-1:0];
               state_ff <= S_HB0;
            end
            S_HB0:   state_ff <= S_LB0;
            S_LB0: begin
               hp0_ff   <= prod_ff[49:0];
               hy_ff    <= hy_new[STATE_W-1:0];
               state_ff <= S_HA1;
            end
            S_HA1: begin
               lp0_ff   <= prod_ff[49:0];
               ly_ff    <= ly_new[STATE_W-1:0];
               state_ff <= S_HA2;
            end
            S_HA2: begin
               hs1n_ff  <= hs1_new[STATE_W-1:0];
               state_ff <= S_LA1;
            end
            S_LA1: begin
               hs2n_ff  <= hs2_new[STATE_W-1:0];
               state_ff <= S_LA2;
            end
            S_LA2: begin
               ls1n_ff  <= ls1_new[STATE_W-1:0];
               state_ff <= S_DRV;
            end
            S_DRV: begin
               ls2n_ff  <= ls2_new[STATE_W-1:0];
               state_ff <= S_SUB;
            end
            S_SUB: begin
               arg_ff   <= prod_ff[57:0];
               state_ff <= S_POS;
            end
            S_POS: begin
               sub_ff   <= sub_new[35:0];
               state_ff <= S_ROM;
            end
            S_ROM: begin
               frac_ff  <= prod_ff[44:29];
               state_ff <= S_INTP;
            end
            S_INTP:  state_ff <= S_DIFF;
            S_DIFF: begin
               diff_ff  <= diff_new[37:0];
               state_ff <= S_BLEND;
            end
            S_BLEND: state_ff <= S_MIX;
            S_MIX: begin
               m_ff     <= m_new[39:0];
               state_ff <= S_OG;
            end
            S_OG:    state_ff <= S_OUT;
            S_OUT: begin
               res_ff[ch_ff] <= o_val[SAMPLE_BITS-1:0];
               if (ch_ff == 1'(ACTIVE - 1)) begin
                  state_ff <= S_DONE;
               end else begin
                  ch_ff    <= 1'b1;
                  state_ff <= S_GAIN;
               end
            end
            S_DONE: begin
               if (ctl.ack) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Each channel's entry is read at its start and written back mid-way; the
   // next read of an entry comes only with a later item, so no forwarding.
   bss_state_mem #(
      .DEPTH (CHANNELS),
      .AW    (AW),
      .WIDTH (MW)
   ) u_state (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (state_ff == S_GAIN),
      .rd_addr (AW'(ch_ff)),
      .rd_data (mem_rdata),
      .wr_en   (state_ff == S_SUB),
      .wr_addr (AW'(ch_ff)),
      .wr_data ({hs1n_ff, hs2n_ff, ls1n_ff, ls2n_ff})
   );

   bss_tanh_rom #(
      .ENTRIES (TANH_ENTRIES),
      .TI      (TI)
   ) u_tanh (
      .clock   (clock),
      .rd_en   (state_ff == S_ROM),
      .addr_lo (idx),
      .addr_hi (idx + TI'(1)),
      .data_lo (tbl_lo),
      .data_hi (tbl_hi)
   );

   assign sts.done     = (state_ff == S_DONE);
   assign left_result  = res_ff[0];
   assign right_result = res_ff[1];

endmodule

// File: hw/rtl/bss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bass saturation port checker
// Watches the core's handshake ports for ordering and hold behavior.
// ----------------------------------------------------------------------------
module bss_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // A pending result stays offered until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // Only one item is worked on at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in progress");

   // A new result frees the engine in the same cycle.
   a_free_on_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("engine still busy when its result appeared");

endmodule

bind bass_saturation_stereo_channel_core bss_checker u_bss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);
